### sv/dns_name_decompressor_defines.svh
// ----------------------------------------------------------------------------
// DNS name decompressor assertion macros
// Shared property shapes for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_DECOMPRESSOR_DEFINES_SVH
`define DNS_NAME_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DND_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DND_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dnd_pkg.sv
// ----------------------------------------------------------------------------
// dnd_pkg
// Constants, codes and hand-off types of the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnd_pkg;

    localparam int BUFFER_BYTES = 512;
    localparam int PKT_AW       = $clog2(BUFFER_BYTES);
    localparam int MAX_HOPS     = 8;
    localparam int HOP_W        = 4;
    localparam int TEXT_CAP     = 256;
    localparam int TXT_AW       = $clog2(TEXT_CAP);

    localparam logic [8:0]  CAP_RESET   = 9'd256;
    localparam logic [7:0]  PTR_MASK    = 8'hc0;
    localparam logic [13:0] OFFSET_MASK = 14'h3fff;
    localparam logic [7:0]  NUL_BYTE    = 8'h00;
    localparam logic [7:0]  DOT_CHAR    = 8'h2e;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_LONG = 3'd1;
    localparam logic [2:0] ST_PTR_OFF  = 3'd2;
    localparam logic [2:0] ST_HOPS     = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    // Finished decode handed from the walker to the packer.
    typedef struct packed {
        logic       start;
        logic [8:0] text_len;
        logic [2:0] status;
        logic [8:0] enc_len;
    } dnd_job_t;

endpackage

### sv/dnd_ram.sv
// ----------------------------------------------------------------------------
// dnd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/dnd_walker.sv
// ----------------------------------------------------------------------------
// dnd_walker
// Walks a compressed name through the packet store, writes the dotted text
// into the text store and reports status and encoded length.
// ----------------------------------------------------------------------------
`include "dns_name_decompressor_defines.svh"

module dnd_walker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [13:0]               start_pos,
    input  logic [14:0]               packet_len,
    input  logic                      allow,
    input  logic [8:0]                max_out_len,
    output logic                      pkt_re,
    output logic [dnd_pkg::PKT_AW-1:0] pkt_raddr,
    input  logic [7:0]                pkt_rdata,
    output logic                      txt_we,
    output logic [dnd_pkg::TXT_AW-1:0] txt_waddr,
    output logic [7:0]                txt_wdata,
    output logic                      busy,
    output dnd_pkg::dnd_job_t         job
);

    typedef enum logic [5:0] {
        W_IDLE  = 6'b000001,
        W_FETCH = 6'b000010,
        W_LEN   = 6'b000100,
        W_COPY  = 6'b001000,
        W_DOT   = 6'b010000,
        W_PTR   = 6'b100000
    } walk_state_t;

    walk_state_t state_reg, state_next;
    logic [13:0] pos_reg, pos_next;
    logic [14:0] limit_reg, limit_next;
    logic        allow_reg, allow_next;
    logic [8:0]  tc_reg, tc_next;
    logic [8:0]  ec_reg, ec_next;
    logic [dnd_pkg::HOP_W-1:0] hops_reg, hops_next;
    logic        at_start_reg, at_start_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  hi_reg, hi_next;
    dnd_pkg::dnd_job_t job_reg, job_next;

    logic [8:0]  cap;
    logic        fin;
    logic [2:0]  fin_status;
    logic [13:0] pos_inc;

    assign cap = (max_out_len > 9'(dnd_pkg::TEXT_CAP)) ? 9'(dnd_pkg::TEXT_CAP) : max_out_len;
    assign pos_inc = pos_reg + 14'd1;

    // Length byte is read at pos; label bytes and pointer low byte at pos + 1.
    assign pkt_re    = (state_reg != W_IDLE);
    assign pkt_raddr = (state_reg == W_FETCH) ? pos_reg[dnd_pkg::PKT_AW-1:0]
                                              : pos_inc[dnd_pkg::PKT_AW-1:0];
    assign busy      = (state_reg != W_IDLE);
    assign job       = job_reg;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        limit_next    = limit_reg;
        allow_next    = allow_reg;
        tc_next       = tc_reg;
        ec_next       = ec_reg;
        hops_next     = hops_reg;
        at_start_next = at_start_reg;
        cnt_next      = cnt_reg;
        hi_next       = hi_reg;
        job_next      = '0;
        txt_we        = 1'b0;
        txt_waddr     = tc_reg[dnd_pkg::TXT_AW-1:0];
        txt_wdata     = pkt_rdata;
        fin           = 1'b0;
        fin_status    = dnd_pkg::ST_OK;

        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    pos_next      = start_pos;
                    limit_next    = (packet_len > 15'(dnd_pkg::BUFFER_BYTES))
                                    ? 15'(dnd_pkg::BUFFER_BYTES) : packet_len;
                    allow_next    = allow;
                    tc_next       = '0;
                    ec_next       = '0;
                    hops_next     = '0;
                    at_start_next = 1'b1;
                    state_next    = W_FETCH;
                end
            end
            W_FETCH:
            begin
                if ({1'b0, pos_reg} >= limit_reg)
                begin
                    fin        = 1'b1;
                    fin_status = dnd_pkg::ST_RANGE;
                end
                else
                begin
                    state_next = W_LEN;
                end
            end
            W_LEN:
            begin
                if (pkt_rdata == dnd_pkg::NUL_BYTE)
                begin
                    ec_next = ec_reg + 9'(at_start_reg);
                    fin     = 1'b1;
                end
                else if ((pkt_rdata & dnd_pkg::PTR_MASK) == 8'h00)
                begin
                    if ({1'b0, tc_reg} + {2'b00, pkt_rdata} + 10'd1 > {1'b0, cap})
                    begin
                        fin        = 1'b1;
                        fin_status = dnd_pkg::ST_TOO_LONG;
                    end
                    else if ({1'b0, pos_reg} + {7'd0, pkt_rdata} >= limit_reg)
                    begin
                        fin        = 1'b1;
                        fin_status = dnd_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cnt_next   = pkt_rdata[5:0];
                        pos_next   = pos_inc;
                        if (at_start_reg)
                        begin
                            ec_next = ec_reg + {1'b0, pkt_rdata} + 9'd1;
                        end
                        state_next = W_COPY;
                    end
                end
                else
                begin
                    if (!allow_reg)
                    begin
                        fin        = 1'b1;
                        fin_status = dnd_pkg::ST_PTR_OFF;
                    end
                    else if ({1'b0, pos_inc} >= limit_reg)
                    begin
                        fin        = 1'b1;
                        fin_status = dnd_pkg::ST_RANGE;
                    end
                    else if (hops_reg >= dnd_pkg::HOP_W'(dnd_pkg::MAX_HOPS))
                    begin
                        fin        = 1'b1;
                        fin_status = dnd_pkg::ST_HOPS;
                    end
                    else
                    begin
                        hops_next     = hops_reg + dnd_pkg::HOP_W'(1);
                        if (at_start_reg)
                        begin
                            ec_next = ec_reg + 9'd2;
                        end
                        at_start_next = 1'b0;
                        hi_next       = pkt_rdata[5:0];
                        state_next    = W_PTR;
                    end
                end
            end
            W_COPY:
            begin
                txt_we   = 1'b1;
                tc_next  = tc_reg + 9'd1;
                pos_next = pos_inc;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = W_DOT;
                end
            end
            W_DOT:
            begin
                txt_we     = 1'b1;
                txt_wdata  = dnd_pkg::DOT_CHAR;
                tc_next    = tc_reg + 9'd1;
                state_next = W_FETCH;
            end
            W_PTR:
            begin
                pos_next   = {hi_reg, pkt_rdata} & dnd_pkg::OFFSET_MASK;
                state_next = W_FETCH;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next      = W_IDLE;
            job_next.start  = 1'b1;
            job_next.status = fin_status;
            if (fin_status == dnd_pkg::ST_OK)
            begin
                // drop the trailing dot
                job_next.text_len = (tc_reg == 9'd0) ? 9'd0 : tc_reg - 9'd1;
                job_next.enc_len  = ec_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= W_IDLE;
            pos_reg      <= '0;
            limit_reg    <= '0;
            allow_reg    <= 1'b0;
            tc_reg       <= '0;
            ec_reg       <= '0;
            hops_reg     <= '0;
            at_start_reg <= 1'b0;
            cnt_reg      <= '0;
            hi_reg       <= '0;
            job_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            limit_reg    <= limit_next;
            allow_reg    <= allow_next;
            tc_reg       <= tc_next;
            ec_reg       <= ec_next;
            hops_reg     <= hops_next;
            at_start_reg <= at_start_next;
            cnt_reg      <= cnt_next;
            hi_reg       <= hi_next;
            job_reg      <= job_next;
        end
    end

    `DND_ASSERT_IMP(a_hops_bounded, state_reg != W_IDLE,
        hops_reg <= dnd_pkg::HOP_W'(dnd_pkg::MAX_HOPS), "hop count passed its limit")
    `DND_ASSERT_IMP(a_text_in_range, txt_we,
        tc_reg < 9'(dnd_pkg::TEXT_CAP), "text write beyond text store")

endmodule

### sv/dnd_packer.sv
// ----------------------------------------------------------------------------
// dnd_packer
// Reads the decoded text back one character at a time, packs up to four per
// result and drives the registered result port.
// ----------------------------------------------------------------------------
`include "dns_name_decompressor_defines.svh"

module dnd_packer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dnd_pkg::dnd_job_t          job,
    output logic                       txt_re,
    output logic [dnd_pkg::TXT_AW-1:0] txt_raddr,
    input  logic [7:0]                 txt_rdata,
    output logic                       busy,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [7:0]                 char0,
    output logic [7:0]                 char1,
    output logic [7:0]                 char2,
    output logic [7:0]                 char3,
    output logic [2:0]                 char_count,
    output logic                       last,
    output logic [2:0]                 status,
    output logic [8:0]                 encoded_len
);

    typedef enum logic [2:0] {
        P_IDLE   = 3'b001,
        P_GATHER = 3'b010,
        P_PUSH   = 3'b100
    } pack_state_t;

    pack_state_t state_reg, state_next;
    logic [8:0]       len_reg, len_next;
    logic [2:0]       st_reg, st_next;
    logic [8:0]       enc_reg, enc_next;
    logic [8:0]       gidx_reg, gidx_next;
    logic [2:0]       lane_reg, lane_next;
    logic             pend_reg, pend_next;
    logic [3:0][7:0]  chars_reg, chars_next;

    logic             out_valid_reg, out_valid_next;
    logic [3:0][7:0]  out_chars_reg, out_chars_next;
    logic [2:0]       out_count_reg, out_count_next;
    logic             out_last_reg, out_last_next;
    logic [2:0]       out_status_reg, out_status_next;
    logic [8:0]       out_enc_reg, out_enc_next;

    logic             can_issue;
    logic             push;
    logic             is_last;

    assign busy    = (state_reg != P_IDLE);
    assign is_last = (gidx_reg == len_reg);
    assign push    = (state_reg == P_PUSH) && (!out_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        st_next    = st_reg;
        enc_next   = enc_reg;
        gidx_next  = gidx_reg;
        lane_next  = lane_reg;
        pend_next  = pend_reg;
        chars_next = chars_reg;
        txt_re     = 1'b0;
        txt_raddr  = gidx_reg[dnd_pkg::TXT_AW-1:0];
        can_issue  = 1'b0;

        unique case (state_reg)
            P_IDLE:
            begin
                if (job.start)
                begin
                    len_next   = job.text_len;
                    st_next    = job.status;
                    enc_next   = job.enc_len;
                    gidx_next  = '0;
                    lane_next  = '0;
                    pend_next  = 1'b0;
                    chars_next = '0;
                    state_next = P_GATHER;
                end
            end
            P_GATHER:
            begin
                // capture the read issued last cycle, then issue the next one
                if (pend_reg)
                begin
                    chars_next[lane_reg[1:0]] = txt_rdata;
                end
                lane_next = lane_reg + 3'(pend_reg);
                can_issue = (lane_next < 3'd4) && (gidx_reg < len_reg);
                if (can_issue)
                begin
                    txt_re    = 1'b1;
                    gidx_next = gidx_reg + 9'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = P_PUSH;
                end
            end
            P_PUSH:
            begin
                if (push)
                begin
                    chars_next = '0;
                    lane_next  = '0;
                    state_next = is_last ? P_IDLE : P_GATHER;
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_chars_next  = out_chars_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_enc_next    = out_enc_reg;
        if (push)
        begin
            out_valid_next  = 1'b1;
            out_chars_next  = chars_reg;
            out_count_next  = lane_reg;
            out_last_next   = is_last;
            out_status_next = is_last ? st_reg : dnd_pkg::ST_OK;
            out_enc_next    = is_last ? enc_reg : 9'd0;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= P_IDLE;
            len_reg        <= '0;
            st_reg         <= '0;
            enc_reg        <= '0;
            gidx_reg       <= '0;
            lane_reg       <= '0;
            pend_reg       <= 1'b0;
            chars_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_chars_reg  <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= '0;
            out_enc_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            st_reg         <= st_next;
            enc_reg        <= enc_next;
            gidx_reg       <= gidx_next;
            lane_reg       <= lane_next;
            pend_reg       <= pend_next;
            chars_reg      <= chars_next;
            out_valid_reg  <= out_valid_next;
            out_chars_reg  <= out_chars_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
            out_enc_reg    <= out_enc_next;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign char0       = out_chars_reg[0];
    assign char1       = out_chars_reg[1];
    assign char2       = out_chars_reg[2];
    assign char3       = out_chars_reg[3];
    assign char_count  = out_count_reg;
    assign last        = out_last_reg;
    assign status      = out_status_reg;
    assign encoded_len = out_enc_reg;

    `DND_ASSERT_IMP(a_err_empty, out_valid_reg && out_status_reg != dnd_pkg::ST_OK,
        out_count_reg == 3'd0 && out_last_reg && out_enc_reg == 9'd0,
        "error result carries text")
    `DND_ASSERT_IMP(a_full_groups, out_valid_reg && !out_last_reg,
        out_count_reg == 3'd4, "short group before the last one")
    `DND_ASSERT_IMP(a_gather_bound, state_reg == P_GATHER,
        gidx_reg <= len_reg, "text read past decoded length")
    `DND_ASSERT_NXT(a_push_shows, push, out_valid_reg, "pushed result not presented")

endmodule

### sv/dns_name_decompressor.sv
// ----------------------------------------------------------------------------
// dns_name_decompressor
// Loads packet bytes into a buffer and decodes compressed DNS names at an
// offset into dotted text, up to four characters per result.
//
// Channel    Direction  Handshake               Payload
// request    in         req_valid / req_stall   command data_byte offset
//                                               packet_len allow_pointers
// result     out        rsp_valid / rsp_stall   char0..char3 char_count last
//                                               status encoded_len
// config     in         cfg_wr_en               cfg_wr_data (max_out_len)
//
// A load writes the packet store port directly.
// A decode walks the name one packet-store read per cycle: fetch, length,
// label bytes and dot per label, low byte per pointer; the text store is
// then read back one character per cycle while the output is not stalled.
// No clearing pass after reset; the packet store holds garbage until loaded.
// rsp_stall holds the output register; the next request is taken as soon as
// the last result of a decode sits in that register.
// ----------------------------------------------------------------------------
module dns_name_decompressor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic [13:0] offset,
    input  logic [14:0] packet_len,
    input  logic        allow_pointers,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  char0,
    output logic [7:0]  char1,
    output logic [7:0]  char2,
    output logic [7:0]  char3,
    output logic [2:0]  char_count,
    output logic        last,
    output logic [2:0]  status,
    output logic [8:0]  encoded_len,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    logic [8:0] max_out_len_reg;
    logic       accept;
    logic       load_we;
    logic       decode_start;
    logic       w_busy;
    logic       p_busy;

    logic                       pkt_re;
    logic [dnd_pkg::PKT_AW-1:0] pkt_raddr;
    logic [7:0]                 pkt_rdata;
    logic                       txt_we;
    logic [dnd_pkg::TXT_AW-1:0] txt_waddr;
    logic [7:0]                 txt_wdata;
    logic                       txt_re;
    logic [dnd_pkg::TXT_AW-1:0] txt_raddr;
    logic [7:0]                 txt_rdata;
    dnd_pkg::dnd_job_t          job;

    // Hold requests while a decode or its read-back is in flight.
    assign req_stall    = w_busy || p_busy || job.start;
    assign accept       = req_valid && !req_stall;
    assign load_we      = accept && (command == dnd_pkg::CMD_LOAD)
                          && ({1'b0, offset} < 15'(dnd_pkg::BUFFER_BYTES));
    assign decode_start = accept && (command == dnd_pkg::CMD_DECODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_out_len_reg <= dnd_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_out_len_reg <= cfg_wr_data;
        end
    end

    // Loads and decode reads never overlap: loads are taken only while idle.
    dnd_ram #(
        .WIDTH (8),
        .DEPTH (dnd_pkg::BUFFER_BYTES)
    ) u_pkt_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (offset[dnd_pkg::PKT_AW-1:0]),
        .wdata (data_byte),
        .re    (pkt_re),
        .raddr (pkt_raddr),
        .rdata (pkt_rdata)
    );

    dnd_ram #(
        .WIDTH (8),
        .DEPTH (dnd_pkg::TEXT_CAP)
    ) u_txt_ram (
        .clk   (clk),
        .we    (txt_we),
        .waddr (txt_waddr),
        .wdata (txt_wdata),
        .re    (txt_re),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    dnd_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (decode_start),
        .start_pos   (offset),
        .packet_len  (packet_len),
        .allow       (allow_pointers),
        .max_out_len (max_out_len_reg),
        .pkt_re      (pkt_re),
        .pkt_raddr   (pkt_raddr),
        .pkt_rdata   (pkt_rdata),
        .txt_we      (txt_we),
        .txt_waddr   (txt_waddr),
        .txt_wdata   (txt_wdata),
        .busy        (w_busy),
        .job         (job)
    );

    dnd_packer u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .txt_re      (txt_re),
        .txt_raddr   (txt_raddr),
        .txt_rdata   (txt_rdata),
        .busy        (p_busy),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .char0       (char0),
        .char1       (char1),
        .char2       (char2),
        .char3       (char3),
        .char_count  (char_count),
        .last        (last),
        .status      (status),
        .encoded_len (encoded_len)
    );

endmodule
